@@ design/scfb_pkg.sv @@
// Shared types, constants and functions of the serial command frame builder.
// Holds the microcode table and the byte-wise CRC-16 update; no dependencies.
package scfb_pkg;

  localparam logic [7:0]  FRAME_START = 8'hA5;
  localparam logic [7:0]  ADDR_RESET  = 8'h3F;
  localparam int          CRC_W       = 16;
  localparam logic [15:0] CRC16_GEN   = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;
  localparam int          SEQ_W       = 4;
  localparam int          PC_W        = 4;

  // control byte: low two bits carry the frame kind
  localparam logic [1:0] KIND_COMMAND = 2'd2;
  localparam logic [1:0] KIND_QUERY   = 2'd1;

  typedef logic [PC_W-1:0] pc_t;

  // byte source for the current step
  typedef enum logic [3:0] {
    SRC_START,
    SRC_ADDR,
    SRC_CTRL,
    SRC_INDEX,
    SRC_OFFSET,
    SRC_COUNT,
    SRC_CRC_HI,
    SRC_CRC_LO,
    SRC_DATA
  } src_t;

  typedef enum logic [1:0] {
    END_NEVER,
    END_ALWAYS,
    END_IF_QUERY
  } end_t;

  typedef enum logic [1:0] {
    BR_SEQ,         // fall through
    BR_DATA_ENTRY,  // jump to target when no data bytes remain
    BR_DATA_LOOP    // repeat this step until the last data byte
  } br_t;

  typedef struct packed {
    src_t src;
    logic crc_upd;
    logic crc_clr;
    end_t fin;
    br_t  br;
    pc_t  target;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    src_t src;
    logic crc_upd;
    logic crc_clr;
    logic last;
  } dp_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic is_query;
    logic data_zero;
    logic data_one;
  } dp_stat_t;

  localparam pc_t PC_DATA_CRC_HI = 4'd9;
  localparam pc_t PC_LAST        = 4'd10;

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:  w = '{SRC_START,  1'b1, 1'b0, END_NEVER,    BR_SEQ,        '0};
      4'd1:  w = '{SRC_ADDR,   1'b1, 1'b0, END_NEVER,    BR_SEQ,        '0};
      4'd2:  w = '{SRC_CTRL,   1'b1, 1'b0, END_NEVER,    BR_SEQ,        '0};
      4'd3:  w = '{SRC_INDEX,  1'b1, 1'b0, END_NEVER,    BR_SEQ,        '0};
      4'd4:  w = '{SRC_OFFSET, 1'b1, 1'b0, END_NEVER,    BR_SEQ,        '0};
      4'd5:  w = '{SRC_COUNT,  1'b1, 1'b0, END_NEVER,    BR_SEQ,        '0};
      4'd6:  w = '{SRC_CRC_HI, 1'b0, 1'b0, END_NEVER,    BR_SEQ,        '0};
      // header CRC done: restart the CRC for the data section
      4'd7:  w = '{SRC_CRC_LO, 1'b0, 1'b1, END_IF_QUERY, BR_DATA_ENTRY, PC_DATA_CRC_HI};
      4'd8:  w = '{SRC_DATA,   1'b1, 1'b0, END_NEVER,    BR_DATA_LOOP,  '0};
      4'd9:  w = '{SRC_CRC_HI, 1'b0, 1'b0, END_NEVER,    BR_SEQ,        '0};
      4'd10: w = '{SRC_CRC_LO, 1'b0, 1'b0, END_ALWAYS,   BR_SEQ,        '0};
      default: w = '{SRC_START, 1'b0, 1'b0, END_ALWAYS,  BR_SEQ,        '0};
    endcase
    return w;
  endfunction

  // one byte into CRC-16, MSB first, no reflection
  function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] acc, logic [7:0] b);
    logic [CRC_W-1:0] c;
    logic [CRC_W-1:0] d;
    c = acc;
    d = {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (((d ^ c) & CRC_TOP) != '0) begin
        c = (c << 1) ^ CRC16_GEN;
      end else begin
        c = c << 1;
      end
      d = d << 1;
    end
    return c;
  endfunction

endpackage

@@ design/scfb_sequencer.sv @@
// Microcode sequencer: step counter, control word lookup and branch logic.
// Depends on scfb_pkg for the microcode table and control types.
module scfb_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               step,
  input  scfb_pkg::dp_stat_t stat,
  output logic               busy,
  output scfb_pkg::dp_ctrl_t ctrl
);

  logic                busy_r, busy_nxt;
  scfb_pkg::pc_t       pc_r, pc_nxt;
  scfb_pkg::uword_t    uw;
  logic                last;
  scfb_pkg::pc_t       pc_br;

  always_comb begin
    uw   = scfb_pkg::ucode(pc_r);
    last = (uw.fin == scfb_pkg::END_ALWAYS) ||
           ((uw.fin == scfb_pkg::END_IF_QUERY) && stat.is_query);

    unique case (uw.br)
      scfb_pkg::BR_SEQ:        pc_br = pc_r + scfb_pkg::PC_W'(1);
      scfb_pkg::BR_DATA_ENTRY: pc_br = stat.data_zero ? uw.target
                                                      : pc_r + scfb_pkg::PC_W'(1);
      scfb_pkg::BR_DATA_LOOP:  pc_br = stat.data_one ? pc_r + scfb_pkg::PC_W'(1) : pc_r;
      default:                 pc_br = pc_r + scfb_pkg::PC_W'(1);
    endcase

    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    priority if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (step) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_br;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy         = busy_r;
  assign ctrl.src     = uw.src;
  assign ctrl.crc_upd = uw.crc_upd;
  assign ctrl.crc_clr = uw.crc_clr;
  assign ctrl.last    = last;

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= scfb_pkg::PC_LAST))
    else $error("sequencer step counter ran past the program");

  a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && (pc_r == '0)))
    else $error("frame did not start at the first microcode step");

endmodule

@@ design/scfb_datapath.sv @@
// Frame datapath: request registers, sequence counter, CRC, byte select, output register.
// Depends on scfb_pkg for control types, constants and the CRC function.
module scfb_datapath #(
  parameter int MAX_WORDS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               in_op,
  input  logic [7:0]         in_cmd_index,
  input  logic [7:0]         in_sub_offset,
  input  logic [31:0]        in_write_value,
  input  logic [1:0]         in_word_count,
  input  logic [7:0]         drive_address,
  input  logic               step,
  input  scfb_pkg::dp_ctrl_t ctrl,
  output scfb_pkg::dp_stat_t stat,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_frame_byte,
  output logic               out_last_byte,
  output logic [3:0]         out_seq_number
);

  localparam int DL_W = $clog2(2 * MAX_WORDS + 1);

  logic                       op_r;
  logic [7:0]                 index_r;
  logic [7:0]                 offset_r;
  logic [1:0]                 count_r;
  logic [31:0]                val_r, val_nxt;
  logic [DL_W-1:0]            left_r, left_nxt;
  logic [scfb_pkg::SEQ_W-1:0] seq_r;
  logic [scfb_pkg::CRC_W-1:0] crc_r, crc_nxt;
  logic                       out_valid_r;
  logic [7:0]                 out_byte_r;
  logic                       out_last_r;
  logic [scfb_pkg::SEQ_W-1:0] out_seq_r;

  logic [1:0]                 nw_sat;
  logic [7:0]                 byte_sel;

  assign nw_sat = (int'(in_word_count) > MAX_WORDS) ? 2'(MAX_WORDS) : in_word_count;

  always_comb begin
    unique case (ctrl.src)
      scfb_pkg::SRC_START:  byte_sel = scfb_pkg::FRAME_START;
      scfb_pkg::SRC_ADDR:   byte_sel = drive_address;
      scfb_pkg::SRC_CTRL:   byte_sel = {2'b00, seq_r,
                                        op_r ? scfb_pkg::KIND_QUERY : scfb_pkg::KIND_COMMAND};
      scfb_pkg::SRC_INDEX:  byte_sel = index_r;
      scfb_pkg::SRC_OFFSET: byte_sel = offset_r;
      scfb_pkg::SRC_COUNT:  byte_sel = {6'b0, count_r};
      scfb_pkg::SRC_CRC_HI: byte_sel = crc_r[15:8];
      scfb_pkg::SRC_CRC_LO: byte_sel = crc_r[7:0];
      scfb_pkg::SRC_DATA:   byte_sel = val_r[7:0];
      default:              byte_sel = 8'h00;
    endcase

    crc_nxt  = crc_r;
    left_nxt = left_r;
    val_nxt  = val_r;
    if (step) begin
      if (ctrl.crc_clr) begin
        crc_nxt = '0;
      end else if (ctrl.crc_upd) begin
        crc_nxt = scfb_pkg::crc_byte(crc_r, byte_sel);
      end
      // value goes out low byte first; zeros fill past the fourth byte
      if (ctrl.src == scfb_pkg::SRC_DATA) begin
        left_nxt = left_r - DL_W'(1);
        val_nxt  = {8'h00, val_r[31:8]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        seq_r <= seq_r + scfb_pkg::SEQ_W'(1);
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r     <= in_op;
      index_r  <= in_cmd_index;
      offset_r <= in_sub_offset;
      count_r  <= nw_sat;
      val_r    <= in_write_value;
      left_r   <= DL_W'({nw_sat, 1'b0});
      crc_r    <= '0;
    end else begin
      val_r    <= val_nxt;
      left_r   <= left_nxt;
      crc_r    <= crc_nxt;
    end
    if (step) begin
      out_byte_r <= byte_sel;
      out_last_r <= ctrl.last;
      out_seq_r  <= seq_r;
    end
  end

  assign stat.is_query   = op_r;
  assign stat.data_zero  = (left_r == '0);
  assign stat.data_one   = (left_r == DL_W'(1));
  assign slot_free       = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_frame_byte  = out_byte_r;
  assign out_last_byte   = out_last_r;
  assign out_seq_number  = out_seq_r;

endmodule

@@ design/serial_command_frame_builder.sv @@
// Serial command frame builder: a query request yields an 8-byte frame, a command
// request 10 + 2*words bytes (words saturated to MAX_WORDS), one byte per clock
// while the output is taken. A microcode sequencer steps one table word per output
// byte, and the CRC-16 (0x1021, init 0) takes each header and data byte on the same
// step. A request is taken no earlier than the cycle after the last byte of the
// previous frame enters the output register, and the output idles between frames.
// drive_address is at byte address 0 and resets to 0x3F.
// Top level; depends on scfb_pkg, scfb_sequencer and scfb_datapath.
module serial_command_frame_builder #(
  parameter int MAX_WORDS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_cmd_index,
  input  logic [7:0]  in_sub_offset,
  input  logic [31:0] in_write_value,
  input  logic [1:0]  in_word_count,
  // frame byte channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte,
  output logic [3:0]  out_seq_number,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               drive_addr_sel;
  logic [7:0]         drive_address_r, drive_address_nxt;
  logic               cfg_wr;
  logic               start;
  logic               step;
  logic               busy;
  logic               slot_free;
  scfb_pkg::dp_ctrl_t ctrl;
  scfb_pkg::dp_stat_t stat;

  // register select: one register, word-aligned
  assign drive_addr_sel = (paddr[2] == 1'b0);
  assign cfg_wr         = psel && penable && pwrite && drive_addr_sel;
  assign pready         = 1'b1;
  assign prdata         = drive_addr_sel ? {24'h0, drive_address_r} : 32'h0;

  always_comb begin
    drive_address_nxt = cfg_wr ? pwdata[7:0] : drive_address_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_address_r <= scfb_pkg::ADDR_RESET;
    end else begin
      drive_address_r <= drive_address_nxt;
    end
  end

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;
  assign step     = busy && slot_free;

  scfb_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .step  (step),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  scfb_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (start),
    .in_op          (in_op),
    .in_cmd_index   (in_cmd_index),
    .in_sub_offset  (in_sub_offset),
    .in_write_value (in_write_value),
    .in_word_count  (in_word_count),
    .drive_address  (drive_address_r),
    .step           (step),
    .ctrl           (ctrl),
    .stat           (stat),
    .slot_free      (slot_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_seq_number (out_seq_number)
  );

  a_one_frame_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("request taken while a frame is in progress");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ctrl.last) |=> (in_ready && out_valid && out_last_byte))
    else $error("final byte did not end the frame");

  a_seq_within_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_byte) |=> (!out_valid || $stable(out_seq_number)))
    else $error("sequence number changed inside a frame");

endmodule

@@ bench/scfb_frame_checker.sv @@
`timescale 1ns / 100ps
// Frame checker for the serial command frame builder: watches the request, frame
// byte and configuration ports, predicts each frame and compares byte by byte.
// Depends on scfb_pkg for the frame constants.
module scfb_frame_checker #(
  parameter int         MAX_WORDS         = 2,
  parameter logic [2:0] DRIVE_ADDR_OFFSET = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_cmd_index,
  input  logic [7:0]  in_sub_offset,
  input  logic [31:0] in_write_value,
  input  logic [1:0]  in_word_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_frame_byte,
  input  logic        out_last_byte,
  input  logic [3:0]  out_seq_number,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          bytes_pending
);

  typedef struct {
    logic [7:0]                 value;
    logic                       last;
    logic [scfb_pkg::SEQ_W-1:0] seq;
  } frame_byte_t;

  frame_byte_t                expected_bytes[$];
  logic [7:0]                 drive_addr_q;
  logic [scfb_pkg::SEQ_W-1:0] seq_q;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc16_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ scfb_pkg::CRC16_GEN;
      end
    end
    return c;
  endfunction

  task automatic predict_frame(input logic is_query, input logic [7:0] idx,
                               input logic [7:0] off, input logic [31:0] val,
                               input logic [1:0] wc);
    logic [7:0]  frame_bytes[0:31];
    logic [15:0] crc;
    frame_byte_t fb;
    int          nw;
    int          n;
    nw = (int'(wc) > MAX_WORDS) ? MAX_WORDS : int'(wc);
    seq_q = seq_q + scfb_pkg::SEQ_W'(1);
    frame_bytes[0] = scfb_pkg::FRAME_START;
    frame_bytes[1] = drive_addr_q;
    frame_bytes[2] = {2'b00, seq_q,
                      is_query ? scfb_pkg::KIND_QUERY : scfb_pkg::KIND_COMMAND};
    frame_bytes[3] = idx;
    frame_bytes[4] = off;
    frame_bytes[5] = 8'(nw);
    crc = '0;
    for (int i = 0; i < 6; i++) begin
      crc = crc16_feed(crc, frame_bytes[i]);
    end
    frame_bytes[6] = crc[15:8];
    frame_bytes[7] = crc[7:0];
    n = 8;
    if (!is_query) begin
      // data CRC starts over; zero words still gives a two-byte CRC of nothing
      crc = '0;
      for (int k = 0; k < 2 * nw; k++) begin
        frame_bytes[n] = (k < 4) ? 8'(val >> (8 * k)) : 8'h00;
        crc = crc16_feed(crc, frame_bytes[n]);
        n++;
      end
      frame_bytes[n]     = crc[15:8];
      frame_bytes[n + 1] = crc[7:0];
      n += 2;
    end
    for (int i = 0; i < n; i++) begin
      fb.value = frame_bytes[i];
      fb.last  = (i == n - 1);
      fb.seq   = seq_q;
      expected_bytes.push_back(fb);
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      drive_addr_q = scfb_pkg::ADDR_RESET;
      seq_q        = '0;
      expected_bytes.delete();
    end else begin
      if (psel && penable && pready && paddr == DRIVE_ADDR_OFFSET) begin
        if (pwrite) begin
          drive_addr_q = pwdata[7:0];
        end else if (prdata[7:0] !== drive_addr_q) begin
          report_mismatch("drive_address read", prdata, 32'(drive_addr_q));
        end
      end
      if (in_valid && in_ready) begin
        predict_frame(in_op, in_cmd_index, in_sub_offset, in_write_value, in_word_count);
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected frame byte", 32'(out_frame_byte), '0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_frame_byte !== want.value) begin
            report_mismatch("frame_byte", 32'(out_frame_byte), 32'(want.value));
          end
          if (out_last_byte !== want.last) begin
            report_mismatch("last_byte", 32'(out_last_byte), 32'(want.last));
          end
          if (out_seq_number !== want.seq) begin
            report_mismatch("seq_number", 32'(out_seq_number), 32'(want.seq));
          end
        end
      end
    end
    bytes_pending = expected_bytes.size();
  end

endmodule

@@ bench/serial_command_frame_builder_test.sv @@
`timescale 1ns / 100ps
// Top of the frame builder bench: clock, reset, request and APB stimulus, output
// back-pressure and the verdict. Depends on scfb_pkg and scfb_frame_checker.
module serial_command_frame_builder_test;

  localparam int         MAX_WORDS      = 2;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         PHASE_ITEMS    = 59;
  localparam logic       OP_COMMAND     = 1'b0;
  localparam logic       OP_QUERY       = 1'b1;
  localparam logic [2:0] REG_DRIVE_ADDR = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [7:0]  in_cmd_index;
  logic [7:0]  in_sub_offset;
  logic [31:0] in_write_value;
  logic [1:0]  in_word_count;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;
  logic [3:0]  out_seq_number;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          bytes_pending;
  bit          steady;  // no idling on either side

  serial_command_frame_builder #(.MAX_WORDS(MAX_WORDS)) DUT (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_op, .in_cmd_index, .in_sub_offset,
    .in_write_value, .in_word_count,
    .out_valid, .out_ready, .out_frame_byte, .out_last_byte, .out_seq_number,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  scfb_frame_checker #(
    .MAX_WORDS(MAX_WORDS),
    .DRIVE_ADDR_OFFSET(REG_DRIVE_ADDR)
  ) u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_op, .in_cmd_index, .in_sub_offset,
    .in_write_value, .in_word_count,
    .out_valid, .out_ready, .out_frame_byte, .out_last_byte, .out_seq_number,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatch_count, .bytes_pending
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input logic op, input logic [7:0] idx, input logic [7:0] off,
                              input logic [31:0] val, input logic [1:0] wc);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_cmd_index   <= idx;
    in_sub_offset  <= off;
    in_write_value <= val;
    in_word_count  <= wc;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic send_random_request();
    send_request(logic'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), $urandom,
                 2'($urandom_range(0, 3)));
  endtask

  // stop sending and let every outstanding frame byte drain
  task automatic drain_frames();
    in_valid <= 1'b0;
    wait (bytes_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_drive_address(input logic [7:0] addr);
    apb_access(1'b1, REG_DRIVE_ADDR, {24'($urandom_range(0, 24'hFFFFFF)), addr});
    apb_access(1'b0, REG_DRIVE_ADDR, '0);
  endtask

  // back-pressure on the frame byte channel, one draw per transfer
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // ends the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [7:0] addr;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_COMMAND;
    in_cmd_index   = '0;
    in_sub_offset  = '0;
    in_write_value = '0;
    in_word_count  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    steady         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset address, field extremes, each word count incl. saturation
    apb_access(1'b0, REG_DRIVE_ADDR, '0);
    send_request(OP_QUERY, 8'h00, 8'h00, 32'h0000_0000, 2'd0);
    send_request(OP_COMMAND, 8'h00, 8'h00, 32'h0000_0000, 2'd0);
    send_request(OP_COMMAND, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 2'd1);
    send_request(OP_COMMAND, 8'h12, 8'h34, 32'hDEAD_BEEF, 2'd2);
    send_request(OP_COMMAND, 8'hA5, 8'h5A, 32'h0123_4567, 2'd3);
    send_request(OP_QUERY, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 2'd3);
    drain_frames();
    set_drive_address(8'hFF);
    send_request(OP_COMMAND, 8'h55, 8'hAA, 32'hA5A5_A5A5, 2'd2);
    send_request(OP_COMMAND, 8'hAA, 8'h55, 32'h5A5A_5A5A, 2'd3);
    send_request(OP_QUERY, 8'h80, 8'h01, 32'h8000_0001, 2'd1);
    send_request(OP_COMMAND, 8'h01, 8'h80, 32'hFFFF_FFFF, 2'd0);
    send_request(OP_QUERY, 8'h7F, 8'hFE, 32'h0000_0000, 2'd2);
    drain_frames();
    set_drive_address(8'h00);
    send_request(OP_COMMAND, 8'hFF, 8'h00, 32'h0000_FFFF, 2'd1);
    send_request(OP_COMMAND, 8'h00, 8'hFF, 32'hFFFF_0000, 2'd2);
    send_request(OP_QUERY, 8'h3C, 8'hC3, 32'h1234_5678, 2'd0);
    send_request(OP_COMMAND, 8'hC3, 8'h3C, 32'h8765_4321, 2'd3);
    // sequence wraps past 15 here
    send_request(OP_QUERY, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 2'd2);
    send_request(OP_COMMAND, 8'h00, 8'h00, 32'hFFFF_FFFF, 2'd2);

    // random phases, each with its own drive address
    for (int phase = 0; phase < 5; phase++) begin
      drain_frames();
      unique case (phase)
        0: addr = 8'hFF;
        1: addr = 8'h00;
        4: addr = scfb_pkg::ADDR_RESET;
        default: addr = 8'($urandom);
      endcase
      set_drive_address(addr);
      steady = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 30) begin
          drain_frames();
        end
        if (phase == 3 && n >= 40) begin
          steady = 1'b1;
        end
        send_random_request();
      end
      steady = 1'b0;
    end

    drain_frames();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/scfb_pkg.sv
design/scfb_sequencer.sv
design/scfb_datapath.sv
design/serial_command_frame_builder.sv
bench/scfb_frame_checker.sv
bench/serial_command_frame_builder_test.sv
